// File: hdl/kmfc_pkg.sv
// Shared types, codes and the key table for the character-driven key matrix.
package kmfc_pkg;

   typedef enum logic [1:0] {
      MODE_CHAR = 2'd0,
      MODE_READ = 2'd1,
      MODE_TICK = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PRESS,
      ST_PURGE
   } state_type;

   // one stored key: code and the millisecond stamp it was pressed at
   typedef struct packed {
      logic [7:0]  code;
      logic [31:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // translation of one host character
   typedef struct packed {
      logic       none;   // character adds no key
      logic       two;    // shift key followed by a second key
      logic [7:0] first;
      logic [7:0] second;
   } keys_type;

   localparam logic [15:0] HOLD_RESET = 16'd100;

   localparam logic [7:0] CAPS_SHIFT = 8'h10;
   localparam logic [7:0] SYM_SHIFT  = 8'h11;
   localparam logic [7:0] CH_SOH     = 8'h01;
   localparam logic [7:0] CH_BS      = 8'h08;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_ESC     = 8'h1B;
   localparam logic [7:0] CH_DEL     = 8'h7F;
   localparam logic [7:0] ARROW_L    = 8'h80;
   localparam logic [7:0] ARROW_D    = 8'h81;
   localparam logic [7:0] ARROW_U    = 8'h82;
   localparam logic [7:0] ARROW_R    = 8'h83;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_Z    = 8'h5A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;
   localparam logic [2:0] PORT_HIGH  = 3'b111;

   // key codes at row r, column c
   localparam logic [7:0] MATRIX_KEYS [8][5] = '{
      '{8'h10, 8'h7A, 8'h78, 8'h63, 8'h76},
      '{8'h61, 8'h73, 8'h64, 8'h66, 8'h67},
      '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74},
      '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35},
      '{8'h30, 8'h39, 8'h38, 8'h37, 8'h36},
      '{8'h70, 8'h6F, 8'h69, 8'h75, 8'h79},
      '{8'h0D, 8'h6C, 8'h6B, 8'h6A, 8'h68},
      '{8'h20, 8'h11, 8'h6D, 8'h6E, 8'h62}
   };

endpackage

// File: hdl/kmfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/kmfc_xlat.sv
// Host character to key code translation.
module kmfc_xlat (
   input  logic [7:0]        char_code,
   output kmfc_pkg::keys_type keys
);

   logic [7:0] sym_key;
   logic       sym_hit;

   always_comb begin
      sym_hit = 1'b1;
      case (char_code)
         8'h2C:   sym_key = 8'h6E;
         8'h2E:   sym_key = 8'h6D;
         8'h2D:   sym_key = 8'h6A;
         8'h3D:   sym_key = 8'h6C;
         8'h5F:   sym_key = 8'h61;
         8'h3A:   sym_key = 8'h7A;
         8'h3F:   sym_key = 8'h63;
         8'h40:   sym_key = 8'h71;
         8'h23:   sym_key = 8'h33;
         8'h24:   sym_key = 8'h34;
         8'h7E:   sym_key = 8'h32;
         8'h5E:   sym_key = 8'h68;
         8'h26:   sym_key = 8'h36;
         8'h2A:   sym_key = 8'h62;
         8'h7B:   sym_key = 8'h79;
         8'h7D:   sym_key = 8'h75;
         8'h5B:   sym_key = 8'h64;
         8'h5D:   sym_key = 8'h67;
         8'h3B:   sym_key = 8'h6F;
         8'h27:   sym_key = 8'h70;
         default: begin
            sym_key = 8'h00;
            sym_hit = 1'b0;
         end
      endcase
   end

   always_comb begin
      keys.none   = 1'b0;
      keys.two    = 1'b1;
      keys.first  = kmfc_pkg::CAPS_SHIFT;
      keys.second = 8'h30;
      if (char_code == kmfc_pkg::CH_BS || char_code == kmfc_pkg::CH_DEL) begin
         keys.second = 8'h30;
      end else if (char_code == kmfc_pkg::CH_SOH || char_code == kmfc_pkg::CH_ESC) begin
         keys.none = 1'b1;
         keys.two  = 1'b0;
      end else if (char_code == kmfc_pkg::ARROW_L) begin
         keys.second = 8'h37;
      end else if (char_code == kmfc_pkg::ARROW_D) begin
         keys.second = 8'h36;
      end else if (char_code == kmfc_pkg::ARROW_U) begin
         keys.second = 8'h35;
      end else if (char_code == kmfc_pkg::ARROW_R) begin
         keys.second = 8'h38;
      end else if (char_code >= kmfc_pkg::UPPER_A && char_code <= kmfc_pkg::UPPER_Z) begin
         keys.second = char_code + kmfc_pkg::CASE_DIFF;
      end else if (sym_hit) begin
         keys.first  = kmfc_pkg::SYM_SHIFT;
         keys.second = sym_key;
      end else begin
         keys.two   = 1'b0;
         keys.first = char_code;
      end
   end

endmodule

// File: hdl/kmfc_ctrl.sv
// Sequencer: key press scan, purge walk with matrix build, millisecond counter.
module kmfc_ctrl #(
   parameter int KEY_CAPACITY = 64,
   localparam int IDX_W = $clog2(KEY_CAPACITY),
   localparam int CNT_W = $clog2(KEY_CAPACITY + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [1:0]               mode,
   input  kmfc_pkg::keys_type       keys,
   input  logic [7:0]               row_select,
   input  logic [15:0]              hold_time,
   output logic                     busy,
   output logic                     rsp_valid,
   output logic [7:0]               rsp_port_data,
   output logic                     ram_wr_en,
   output logic [IDX_W-1:0]         ram_wr_addr,
   output kmfc_pkg::entry_type      ram_wr_data,
   output logic                     ram_rd_en,
   output logic [IDX_W-1:0]         ram_rd_addr,
   input  kmfc_pkg::entry_type      ram_rd_data
);

   localparam logic [CNT_W-1:0] CAP = CNT_W'(KEY_CAPACITY);

   kmfc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic             pend_ff, pend_in;
   logic [31:0]      now_ff, now_in;
   logic [7:0]       cur_key_ff, cur_key_in;
   logic [7:0]       next_key_ff, next_key_in;
   logic             two_ff, two_in;
   logic [7:0]       sel_ff, sel_in;
   logic [4:0]       acc_ff, acc_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;

   logic             issue;
   logic [31:0]      age;

   // columns pulled low by one held code over the selected rows
   function automatic logic [4:0] col_hits(input logic [7:0] code, input logic [7:0] sel);
      logic [7:0] k;
      logic [4:0] hits;
      k = code;
      hits = 5'b0;
      if (k >= kmfc_pkg::UPPER_A && k <= kmfc_pkg::UPPER_Z) begin
         k = k + kmfc_pkg::CASE_DIFF;
      end
      if (k == kmfc_pkg::CH_LF) begin
         k = kmfc_pkg::CH_CR;
      end
      for (int r = 0; r < 8; r++) begin
         for (int c = 0; c < 5; c++) begin
            if (!sel[r] && kmfc_pkg::MATRIX_KEYS[r][c] == k) begin
               hits[c] = 1'b1;
            end
         end
      end
      return hits;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kmfc_pkg::ST_IDLE;
         count_ff     <= '0;
         now_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         now_ff       <= now_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff   <= rd_ptr_in;
      wr_ptr_ff   <= wr_ptr_in;
      cur_key_ff  <= cur_key_in;
      next_key_ff <= next_key_in;
      two_ff      <= two_in;
      sel_ff      <= sel_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Reads walk upward from entry 0; the purge writes back at wr_ptr, which never
   // passes the read pointer, so a write never lands on an entry still to be read.
   assign issue = (rd_ptr_ff < count_ff);
   assign age   = now_ff - ram_rd_data.stamp;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      pend_in      = 1'b0;
      now_in       = now_ff;
      cur_key_in   = cur_key_ff;
      next_key_in  = next_key_ff;
      two_in       = two_ff;
      sel_in       = sel_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = wr_ptr_ff[IDX_W-1:0];
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = rd_ptr_ff[IDX_W-1:0];

      case (state_ff)
         kmfc_pkg::ST_IDLE: begin
            rd_ptr_in = '0;
            wr_ptr_in = '0;
            if (start) begin
               case (mode)
                  kmfc_pkg::MODE_CHAR: begin
                     cur_key_in  = keys.first;
                     next_key_in = keys.second;
                     two_in      = keys.two;
                     if (!keys.none) begin
                        state_in = kmfc_pkg::ST_PRESS;
                     end
                  end
                  kmfc_pkg::MODE_READ: begin
                     sel_in   = row_select;
                     acc_in   = 5'h1F;
                     state_in = kmfc_pkg::ST_PURGE;
                  end
                  kmfc_pkg::MODE_TICK: begin
                     now_in = now_ff + 32'd1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         kmfc_pkg::ST_PRESS: begin
            logic key_done;
            key_done = 1'b0;
            if (count_ff >= CAP) begin
               key_done = 1'b1;
            end else if (pend_ff && ram_rd_data.code == cur_key_ff) begin
               key_done = 1'b1;
            end else if (!issue && !pend_ff) begin
               // not found: append at the end
               ram_wr_en         = 1'b1;
               ram_wr_addr       = count_ff[IDX_W-1:0];
               ram_wr_data.code  = cur_key_ff;
               ram_wr_data.stamp = now_ff;
               count_in          = count_ff + CNT_W'(1);
               key_done          = 1'b1;
            end else begin
               ram_rd_en = issue;
               pend_in   = issue;
               if (issue) begin
                  rd_ptr_in = rd_ptr_ff + CNT_W'(1);
               end
            end
            if (key_done) begin
               rd_ptr_in = '0;
               pend_in   = 1'b0;
               if (two_ff) begin
                  cur_key_in = next_key_ff;
                  two_in     = 1'b0;
               end else begin
                  state_in = kmfc_pkg::ST_IDLE;
               end
            end
         end

         kmfc_pkg::ST_PURGE: begin
            ram_rd_en = issue;
            pend_in   = issue;
            if (issue) begin
               rd_ptr_in = rd_ptr_ff + CNT_W'(1);
            end
            if (pend_ff && age < {16'b0, hold_time}) begin
               ram_wr_en = 1'b1;
               wr_ptr_in = wr_ptr_ff + CNT_W'(1);
               acc_in    = acc_ff & ~col_hits(ram_rd_data.code, sel_ff);
            end
            if (!issue && !pend_ff) begin
               count_in     = wr_ptr_ff;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {kmfc_pkg::PORT_HIGH, acc_ff};
               state_in     = kmfc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = kmfc_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != kmfc_pkg::ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_port_data = rsp_data_ff;

endmodule

// File: hdl/keyboard_matrix_from_chars.sv
// Top level of the character-driven 8x5 key matrix.
//
// Items enter on start while busy is low, with req_mode selecting the kind:
//   host character (req_char_code): translated to at most two key codes, each
//     looked up in the key store and appended if absent and the store has room;
//   port read (req_row_select, low bits select rows): one walk over the store
//     drops keys held hold_time_ms or longer and ANDs the active-low columns;
//   tick: advances the millisecond counter, done in the accepting cycle.
// Keys live in one RAM (code and stamp per entry) with registered read data;
// the walk issues one read per cycle. The result of a read is on rsp_port_data,
// marked by rsp_valid for exactly one cycle, the first cycle with busy low
// again; the receiver cannot stall, and the next item may be accepted in that
// same cycle. The store holds KEY_CAPACITY keys. The user must write
// hold_time_ms through csr_valid/csr_ready while the block is idle; the block
// itself does not enforce it.
// Synchronous reset empties the store, zeroes the counter and sets the hold
// time to 100 ms; no clearing pass is needed, the fill count guards the RAM.
module keyboard_matrix_from_chars #(
   parameter int KEY_CAPACITY = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_char_code,
   input  logic [7:0]  req_row_select,
   output logic        rsp_valid,
   output logic [7:0]  rsp_port_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_hold_time_ms
);

   localparam int IDX_W = $clog2(KEY_CAPACITY);

   logic [15:0]         hold_time_ff, hold_time_in;
   kmfc_pkg::keys_type  keys;
   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   kmfc_pkg::entry_type ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   kmfc_pkg::entry_type ram_rd_data;
   logic [kmfc_pkg::ENTRY_W-1:0] ram_rd_bits;

   assign csr_ready    = 1'b1;
   assign hold_time_in = (csr_valid && csr_ready) ? csr_hold_time_ms : hold_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_time_ff <= kmfc_pkg::HOLD_RESET;
      end else begin
         hold_time_ff <= hold_time_in;
      end
   end

   kmfc_xlat u_xlat (
      .char_code (req_char_code),
      .keys      (keys)
   );

   kmfc_ctrl #(
      .KEY_CAPACITY (KEY_CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .mode          (req_mode),
      .keys          (keys),
      .row_select    (req_row_select),
      .hold_time     (hold_time_ff),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_port_data (rsp_port_data),
      .ram_wr_en     (ram_wr_en),
      .ram_wr_addr   (ram_wr_addr),
      .ram_wr_data   (ram_wr_data),
      .ram_rd_en     (ram_rd_en),
      .ram_rd_addr   (ram_rd_addr),
      .ram_rd_data   (ram_rd_data)
   );

   kmfc_ram #(
      .WIDTH (kmfc_pkg::ENTRY_W),
      .DEPTH (KEY_CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_data = ram_rd_bits;

   // a write never targets the entry being read in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
      else $error("RAM write and read hit the same entry");

   a_rsp_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && rsp_port_data[7:5] == kmfc_pkg::PORT_HIGH))
      else $error("result shown while busy or with bad high bits");

   a_tick_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == kmfc_pkg::MODE_TICK) |=> (!busy && !rsp_valid))
      else $error("tick item made the block busy or gave a result");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the character-driven 8x5 key matrix.
`timescale 1ns / 100ps

module testbench;

   localparam int          KEYS          = 64;
   localparam int          SETTLE_CYCLES = 300;
   localparam int          WATCHDOG_MAX  = 4000;
   localparam logic [1:0]  MODE_NONE     = 2'd3;

   // expected port data from a running copy of the key store
   class key_scoreboard;
      localparam int CAPACITY = KEYS;
      localparam logic [7:0] CAPS = 8'h10;
      localparam logic [7:0] SYMS = 8'h11;
      // row-major, five columns per row
      localparam logic [0:39][7:0] MATRIX_CODES = {
         8'h10, 8'h7A, 8'h78, 8'h63, 8'h76,
         8'h61, 8'h73, 8'h64, 8'h66, 8'h67,
         8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
         8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
         8'h30, 8'h39, 8'h38, 8'h37, 8'h36,
         8'h70, 8'h6F, 8'h69, 8'h75, 8'h79,
         8'h0D, 8'h6C, 8'h6B, 8'h6A, 8'h68,
         8'h20, 8'h11, 8'h6D, 8'h6E, 8'h62};

      logic [7:0]  held_key [CAPACITY];
      logic [31:0] held_stamp [CAPACITY];
      int          held_total;
      logic [31:0] ms_count;
      logic [15:0] hold_ms;
      logic [7:0]  expected_port [$];
      int          fails;

      function new();
         held_total = 0;
         ms_count   = '0;
         hold_ms    = 16'd100;
         fails      = 0;
      endfunction

      task report_fail(string what);
         $display("ERROR @%0t: %s", $time, what);
         fails++;
      endtask

      function void set_hold(logic [15:0] v);
         hold_ms = v;
      endfunction

      function int pending();
         return expected_port.size();
      endfunction

      function void press(logic [7:0] code);
         if (held_total >= CAPACITY) return;
         for (int i = 0; i < held_total; i++)
            if (held_key[i] == code) return;
         held_key[held_total]   = code;
         held_stamp[held_total] = ms_count;
         held_total++;
      endfunction

      // bit 8 set when the character is one of the symbol-shift characters
      function logic [8:0] symbol_key(logic [7:0] c);
         case (c)
            8'h2C: return {1'b1, 8'h6E};   // , n
            8'h2E: return {1'b1, 8'h6D};   // . m
            8'h2D: return {1'b1, 8'h6A};   // - j
            8'h3D: return {1'b1, 8'h6C};   // = l
            8'h5F: return {1'b1, 8'h61};   // _ a
            8'h3A: return {1'b1, 8'h7A};   // : z
            8'h3F: return {1'b1, 8'h63};   // ? c
            8'h40: return {1'b1, 8'h71};   // @ q
            8'h23: return {1'b1, 8'h33};   // # 3
            8'h24: return {1'b1, 8'h34};   // $ 4
            8'h7E: return {1'b1, 8'h32};   // ~ 2
            8'h5E: return {1'b1, 8'h68};   // ^ h
            8'h26: return {1'b1, 8'h36};   // & 6
            8'h2A: return {1'b1, 8'h62};   // * b
            8'h7B: return {1'b1, 8'h79};   // { y
            8'h7D: return {1'b1, 8'h75};   // } u
            8'h5B: return {1'b1, 8'h64};   // [ d
            8'h5D: return {1'b1, 8'h67};   // ] g
            8'h3B: return {1'b1, 8'h6F};   // ; o
            8'h27: return {1'b1, 8'h70};   // ' p
            default: return 9'h000;
         endcase
      endfunction

      function void take_char(logic [7:0] c);
         logic [8:0] sym;
         sym = symbol_key(c);
         if (c == kmfc_pkg::CH_BS || c == kmfc_pkg::CH_DEL) begin
            press(CAPS); press(8'h30);
         end else if (c == kmfc_pkg::CH_SOH || c == kmfc_pkg::CH_ESC) begin
            // dropped
         end else if (c == kmfc_pkg::ARROW_L) begin
            press(CAPS); press(8'h37);
         end else if (c == kmfc_pkg::ARROW_D) begin
            press(CAPS); press(8'h36);
         end else if (c == kmfc_pkg::ARROW_U) begin
            press(CAPS); press(8'h35);
         end else if (c == kmfc_pkg::ARROW_R) begin
            press(CAPS); press(8'h38);
         end else if (c >= kmfc_pkg::UPPER_A && c <= kmfc_pkg::UPPER_Z) begin
            press(CAPS); press(c + 8'h20);
         end else if (sym[8]) begin
            press(SYMS); press(sym[7:0]);
         end else begin
            press(c);
         end
      endfunction

      function logic [7:0] predict_port(logic [7:0] sel);
         logic [7:0]  port;
         logic [7:0]  k;
         logic [31:0] age;
         int          kept;
         kept = 0;
         for (int r = 0; r < held_total; r++) begin
            age = ms_count - held_stamp[r];
            if (age < {16'h0000, hold_ms}) begin
               held_key[kept]   = held_key[r];
               held_stamp[kept] = held_stamp[r];
               kept++;
            end
         end
         held_total = kept;
         port = 8'hFF;
         for (int i = 0; i < held_total; i++) begin
            k = held_key[i];
            if (k >= kmfc_pkg::UPPER_A && k <= kmfc_pkg::UPPER_Z) k = k + 8'h20;
            if (k == kmfc_pkg::CH_LF) k = kmfc_pkg::CH_CR;
            for (int row = 0; row < 8; row++) begin
               if (!sel[row])
                  for (int col = 0; col < 5; col++)
                     if (MATRIX_CODES[row * 5 + col] == k) port[col] = 1'b0;
            end
         end
         return port | 8'hE0;
      endfunction

      function void note_input(logic [1:0] mode, logic [7:0] ch, logic [7:0] sel);
         case (mode)
            kmfc_pkg::MODE_CHAR: take_char(ch);
            kmfc_pkg::MODE_READ: expected_port.push_back(predict_port(sel));
            kmfc_pkg::MODE_TICK: ms_count = ms_count + 32'd1;
            default: ;
         endcase
      endfunction

      task check_result(logic [7:0] port);
         logic [7:0] want;
         if (expected_port.size() == 0) begin
            report_fail($sformatf("port_data %02h with no read pending", port));
         end else begin
            want = expected_port.pop_front();
            if (port !== want)
               report_fail($sformatf("port_data %02h, expected %02h", port, want));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = kmfc_pkg::MODE_CHAR;
   logic [7:0]  req_char_code = 8'h00;
   logic [7:0]  req_row_select = 8'hFF;
   logic        rsp_valid;
   logic [7:0]  rsp_port_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_hold_time_ms = 16'd0;

   key_scoreboard sb = new();
   int idle_pct = 0;
   int quiet_cycles = 0;

   keyboard_matrix_from_chars #(.KEY_CAPACITY(KEYS)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_char_code(req_char_code),
      .req_row_select(req_row_select),
      .rsp_valid(rsp_valid),
      .rsp_port_data(rsp_port_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_hold_time_ms(csr_hold_time_ms)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // a result and the next item can land on the same edge: check first
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) sb.check_result(rsp_port_data);
         if (start && !busy) sb.note_input(req_mode, req_char_code, req_row_select);
         if (csr_valid && csr_ready) sb.set_hold(csr_hold_time_ms);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("FAIL keyboard_matrix_from_chars");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_item(input logic [1:0] mode, input logic [7:0] ch,
                            input logic [7:0] sel);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start          <= 1'b1;
      req_mode       <= mode;
      req_char_code  <= ch;
      req_row_select <= sel;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // chars produce no result, so give the last one time to finish
   task automatic drain();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_hold(input logic [15:0] v);
      drain();
      while (busy) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_hold_time_ms <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] specials [12];
      int         pick;
      specials = '{kmfc_pkg::CH_BS, kmfc_pkg::CH_DEL, kmfc_pkg::ARROW_L,
                   kmfc_pkg::ARROW_D, kmfc_pkg::ARROW_U, kmfc_pkg::ARROW_R,
                   kmfc_pkg::CH_SOH, kmfc_pkg::CH_ESC, kmfc_pkg::CH_LF,
                   kmfc_pkg::CH_CR, 8'h10, 8'h11};
      pick = $urandom_range(99);
      if (pick < 20) return 8'h61 + 8'($urandom_range(25));         // lower case
      if (pick < 28) return 8'h30 + 8'($urandom_range(9));          // digits
      if (pick < 42) return kmfc_pkg::UPPER_A + 8'($urandom_range(25));
      if (pick < 56) return 8'($urandom_range(8'h20, 8'h7E));       // printable
      if (pick < 68) return specials[$urandom_range(11)];
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [7:0] pick_rows();
      int pick;
      pick = $urandom_range(99);
      if (pick < 50) return 8'($urandom_range(255));
      if (pick < 75) return ~(8'h01 << $urandom_range(7));
      if (pick < 90) return 8'h00;
      return 8'hFF;
   endfunction

   task automatic random_phase(input int count);
      int sent;
      int pick;
      int burst;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_item(kmfc_pkg::MODE_CHAR, pick_char(), 8'($urandom_range(255)));
            sent++;
         end else if (pick < 65) begin
            send_item(kmfc_pkg::MODE_READ, 8'($urandom_range(255)), pick_rows());
            sent++;
         end else if (pick < 98) begin
            burst = $urandom_range(1, 6);
            repeat (burst)
               send_item(kmfc_pkg::MODE_TICK, 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            sent += burst;
         end else begin
            send_item(MODE_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      logic [15:0] hold_plan [6];
      int          idle_plan [6];
      hold_plan = '{16'd100, 16'd1, 16'd65535, 16'd0, 16'd20, 16'd7};
      idle_plan = '{0, 63, 28, 0, 63, 28};

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty reads, every translation class, LF, mode three
      send_item(kmfc_pkg::MODE_READ, 8'h00, 8'hFF);
      send_item(kmfc_pkg::MODE_READ, 8'h00, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, 8'h41, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::CH_BS, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::CH_DEL, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::ARROW_L, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::ARROW_D, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::ARROW_U, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::ARROW_R, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::CH_SOH, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::CH_ESC, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, 8'h2C, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, 8'h27, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::CH_LF, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, 8'h00, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, 8'hFF, 8'h00);
      send_item(kmfc_pkg::MODE_CHAR, kmfc_pkg::UPPER_Z, 8'h00);
      send_item(kmfc_pkg::MODE_READ, 8'hFF, 8'h00);
      send_item(kmfc_pkg::MODE_READ, 8'h00, 8'hFE);
      send_item(kmfc_pkg::MODE_READ, 8'h00, 8'h7F);
      send_item(MODE_NONE, 8'hFF, 8'hFF);
      send_item(kmfc_pkg::MODE_READ, 8'hFF, 8'h55);
      send_item(kmfc_pkg::MODE_TICK, 8'hFF, 8'hFF);
      send_item(kmfc_pkg::MODE_READ, 8'h00, 8'hAA);

      // first phase runs on the reset hold time
      for (int p = 0; p < 6; p++) begin
         if (p != 0) write_hold(hold_plan[p]);
         idle_pct = idle_plan[p];
         random_phase(300);
      end

      drain();
      if (sb.fails == 0)
         $display("PASS keyboard_matrix_from_chars");
      else
         $display("FAIL keyboard_matrix_from_chars");
      $finish;
   end

endmodule
